// File: design/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types and constants of the source text tokenizer: token kinds, the
// token record, character codes and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

  // Field widths of a token request
  localparam int unsigned KindW  = 3;
  localparam int unsigned ValueW = 32;
  localparam int unsigned StrW   = 20;

  // Parameter defaults
  localparam int unsigned TokenLimitDef   = 65536;
  localparam int unsigned BufferCharsDef  = 4096;
  localparam int unsigned PositionBitsDef = 20;

  // Hash seed and character codes
  localparam logic [ValueW-1:0] HashSeed = 32'h0000_1505;
  localparam logic [7:0] ChrSpace = 8'h20;
  localparam logic [7:0] ChrQuote = 8'h22;
  localparam logic [7:0] ChrZero  = 8'h30;
  localparam logic [7:0] ChrNine  = 8'h39;
  localparam logic [7:0] ChrUpA   = 8'h41;
  localparam logic [7:0] ChrUpZ   = 8'h5A;
  localparam logic [7:0] ChrLoA   = 8'h61;
  localparam logic [7:0] ChrLoZ   = 8'h7A;
  localparam logic [7:0] CaseBit  = 8'h20;

  typedef enum logic [KindW-1:0] {
    KIND_NAME = 3'd0,
    KIND_NUM  = 3'd1,
    KIND_SYM  = 3'd2,
    KIND_STR  = 3'd3,
    KIND_ERR  = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [ValueW-1:0] value;
    logic [StrW-1:0]   offset;
    logic [StrW-1:0]   length;
  } token_t;

  // Build a token record
  function automatic token_t mk_token(kind_e kind, logic [ValueW-1:0] value,
                                      logic [StrW-1:0] offset, logic [StrW-1:0] length);
    token_t t;
    t.kind   = kind;
    t.value  = value;
    t.offset = offset;
    t.length = length;
    return t;
  endfunction

endpackage

`default_nettype wire

// File: design/stt_if.sv
// ----------------------------------------------------------------------------
// stt_byte_if / stt_token_if
// Valid/ready channels of the tokenizer: text bytes in, tokens out.
// ----------------------------------------------------------------------------
`default_nettype none

interface stt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       is_last;

  modport source (output valid, output text_byte, output is_last, input ready);
  modport sink   (input valid, input text_byte, input is_last, output ready);
endinterface

interface stt_token_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [31:0] token_value;
  logic [19:0] string_offset;
  logic [19:0] string_chars;
  logic        last_of_run;

  modport source (output valid, output token_kind, output token_value,
                  output string_offset, output string_chars, output last_of_run,
                  input ready);
  modport sink   (input valid, input token_kind, input token_value,
                  input string_offset, input string_chars, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

// File: design/source_text_tokenizer.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Byte-serial lexer: identifiers (case-folded hash), decimal numbers, quoted
// strings, symbols; end of text flushes the pending token or reports an open string.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  text_i    in   valid/ready    text_byte, is_last
//  token_o   out  valid/ready    token_kind, token_value, string_offset,
//                                string_chars, last_of_run
//
//  A byte is lexed in the cycle it is accepted; its tokens (zero to two)
//  land in a three-slot result register and leave one per cycle while token_o is ready.
//  A byte's tokens leave one at a time, through the single token output port.
//  A new byte is taken while the last waiting token is being delivered.
//  Reset clears the lexer state and the token count and empties the result slots.
// ----------------------------------------------------------------------------
`default_nettype none

module source_text_tokenizer import stt_pkg::*; #(
  parameter int unsigned TOKEN_LIMIT   = TokenLimitDef,
  parameter int unsigned BUFFER_CHARS  = BufferCharsDef,
  parameter int unsigned POSITION_BITS = PositionBitsDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  stt_byte_if.sink   text_i,
  stt_token_if.source token_o
);

  localparam int unsigned IssW = $clog2(TOKEN_LIMIT + 1);
  localparam int unsigned PendW = (BUFFER_CHARS > 2) ? $clog2(BUFFER_CHARS) : 1;
  localparam logic [IssW-1:0]  TokLimit = IssW'(TOKEN_LIMIT);
  localparam logic [PendW-1:0] PendMax  = PendW'(BUFFER_CHARS - 1);

  typedef enum logic [1:0] {
    LEX_IDLE,
    LEX_NAME,
    LEX_NUM,
    LEX_STR
  } mode_e;

  // Lexer state
  mode_e                    mode_q, mode_d;
  logic [ValueW-1:0]        hash_q, hash_d;
  logic [ValueW-1:0]        acc_q, acc_d;
  logic [PendW-1:0]         pend_q, pend_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [StrW-1:0]          sbeg_q, sbeg_d;
  logic [StrW-1:0]          scnt_q, scnt_d;
  logic [IssW-1:0]          issued_q, issued_d;
  logic                     ended_q, ended_d;

  // Result slots
  token_t     slot_q [3];
  token_t     kept   [3];
  logic [1:0] cnt_q, rd_q, nkeep;

  token_t                   req [3];
  logic [1:0]               nreq;
  logic [7:0]               c;
  logic [7:0]               lc;
  logic [POSITION_BITS-1:0] pos_inc;
  logic                     is_letter, is_digit, flush_now, keep;
  logic                     in_fire, out_fire;
  logic [1:0]               remain;

  assign c         = text_i.text_byte;
  assign is_digit  = (c >= ChrZero) && (c <= ChrNine);
  assign is_letter = ((c >= ChrUpA) && (c <= ChrUpZ)) || ((c >= ChrLoA) && (c <= ChrLoZ));
  assign lc        = ((c >= ChrUpA) && (c <= ChrUpZ)) ? (c | CaseBit) : c;
  assign pos_inc   = pos_q + POSITION_BITS'(1);

  // Lex one byte: next state and the tokens it requests, in order
  always_comb begin
    mode_d    = mode_q;
    hash_d    = hash_q;
    acc_d     = acc_q;
    pend_d    = pend_q;
    pos_d     = pos_q;
    sbeg_d    = sbeg_q;
    scnt_d    = scnt_q;
    ended_d   = ended_q;
    nreq      = 2'd0;
    flush_now = 1'b0;
    for (int i = 0; i < 3; i++) begin
      req[i] = mk_token(KIND_NAME, '0, '0, '0);
    end

    if (!ended_q) begin
      if (c != 8'd0) begin
        if (mode_d == LEX_STR) begin
          // Inside a string: close on quote, else count
          if (c == ChrQuote) begin
            req[nreq] = mk_token(KIND_STR, '0, sbeg_d, scnt_d);
            nreq      = nreq + 2'd1;
            mode_d    = LEX_IDLE;
          end else begin
            scnt_d = scnt_d + StrW'(1);
          end
        end else begin
          flush_now = (c <= ChrSpace) || (c == ChrQuote) ||
                      ((mode_d == LEX_NAME) && !(is_letter || is_digit)) ||
                      ((mode_d == LEX_NUM) && !is_digit);
          // Flush a pending name or number
          if (flush_now) begin
            if ((mode_d == LEX_NAME) && (pend_d != '0)) begin
              req[nreq] = mk_token(KIND_NAME, hash_d, '0, '0);
              nreq      = nreq + 2'd1;
            end else if ((mode_d == LEX_NUM) && (pend_d != '0)) begin
              req[nreq] = mk_token(KIND_NUM, acc_d, '0, '0);
              nreq      = nreq + 2'd1;
            end
            mode_d = LEX_IDLE;
            hash_d = HashSeed;
            acc_d  = '0;
            pend_d = '0;
          end
          // Act on the byte; a terminator falls through to the idle handling
          if (c <= ChrSpace) begin
            mode_d = mode_d;
          end else if (c == ChrQuote) begin
            mode_d = LEX_STR;
            sbeg_d = StrW'(pos_inc);
            scnt_d = '0;
          end else if (mode_d == LEX_NAME) begin
            if (pend_d < PendMax) begin
              hash_d = (hash_d << 5) + hash_d + ValueW'(lc);
              pend_d = pend_d + PendW'(1);
            end
          end else if (mode_d == LEX_NUM) begin
            if (pend_d < PendMax) begin
              acc_d  = (acc_d << 3) + (acc_d << 1) + ValueW'(c[3:0]);
              pend_d = pend_d + PendW'(1);
            end
          end else if (is_letter) begin
            mode_d = LEX_NAME;
            hash_d = (HashSeed << 5) + HashSeed + ValueW'(lc);
            pend_d = PendW'(1);
          end else if (is_digit) begin
            mode_d = LEX_NUM;
            acc_d  = ValueW'(c[3:0]);
            pend_d = PendW'(1);
          end else begin
            req[nreq] = mk_token(KIND_SYM, ValueW'(c), '0, '0);
            nreq      = nreq + 2'd1;
          end
        end
        pos_d = pos_inc;
      end

      // End of text: report an open string, else flush
      if ((c == 8'd0) || text_i.is_last) begin
        if (mode_d == LEX_STR) begin
          req[nreq] = mk_token(KIND_ERR, '0, sbeg_d, scnt_d);
          nreq      = nreq + 2'd1;
          mode_d    = LEX_IDLE;
        end else begin
          if ((mode_d == LEX_NAME) && (pend_d != '0)) begin
            req[nreq] = mk_token(KIND_NAME, hash_d, '0, '0);
            nreq      = nreq + 2'd1;
          end else if ((mode_d == LEX_NUM) && (pend_d != '0)) begin
            req[nreq] = mk_token(KIND_NUM, acc_d, '0, '0);
            nreq      = nreq + 2'd1;
          end
          mode_d = LEX_IDLE;
          hash_d = HashSeed;
          acc_d  = '0;
          pend_d = '0;
        end
        ended_d = 1'b1;
      end
    end
  end

  // Apply the token limit and pack the surviving tokens
  always_comb begin
    issued_d = issued_q;
    nkeep    = 2'd0;
    keep     = 1'b0;
    for (int i = 0; i < 3; i++) begin
      kept[i] = mk_token(KIND_NAME, '0, '0, '0);
    end
    for (int i = 0; i < 3; i++) begin
      keep = 1'b0;
      if (i < int'(nreq)) begin
        if (req[i].kind == KIND_ERR) begin
          keep = 1'b1;
        end else if (issued_d < TokLimit) begin
          keep     = 1'b1;
          issued_d = issued_d + IssW'(1);
        end
      end
      if (keep) begin
        kept[nkeep] = req[i];
        nkeep       = nkeep + 2'd1;
      end
    end
  end

  // Handshakes
  assign remain       = cnt_q - rd_q;
  assign out_fire     = token_o.valid && token_o.ready;
  assign text_i.ready = (remain == 2'd0) || ((remain == 2'd1) && token_o.ready);
  assign in_fire      = text_i.valid && text_i.ready;

  assign token_o.valid         = (remain != 2'd0);
  assign token_o.token_kind    = slot_q[rd_q].kind;
  assign token_o.token_value   = slot_q[rd_q].value;
  assign token_o.string_offset = slot_q[rd_q].offset;
  assign token_o.string_chars  = slot_q[rd_q].length;
  assign token_o.last_of_run   = (remain == 2'd1);

  // Hold lexer state and slot pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= LEX_IDLE;
      hash_q   <= HashSeed;
      acc_q    <= '0;
      pend_q   <= '0;
      pos_q    <= '0;
      sbeg_q   <= '0;
      scnt_q   <= '0;
      issued_q <= '0;
      ended_q  <= 1'b0;
      cnt_q    <= 2'd0;
      rd_q     <= 2'd0;
    end else if (in_fire) begin
      mode_q   <= mode_d;
      hash_q   <= hash_d;
      acc_q    <= acc_d;
      pend_q   <= pend_d;
      pos_q    <= pos_d;
      sbeg_q   <= sbeg_d;
      scnt_q   <= scnt_d;
      issued_q <= issued_d;
      ended_q  <= ended_d;
      cnt_q    <= nkeep;
      rd_q     <= 2'd0;
    end else if (out_fire) begin
      rd_q <= rd_q + 2'd1;
    end
  end

  // Load result slots
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int i = 0; i < 3; i++) begin
        slot_q[i] <= kept[i];
      end
    end
  end

endmodule

`default_nettype wire
